>>> hw/rtl/split_l1_cache_mesi_lru_defines.svh
// Assertion macros used by the split L1 cache controller.
`ifndef SPLIT_L1_CACHE_MESI_LRU_DEFINES_SVH
`define SPLIT_L1_CACHE_MESI_LRU_DEFINES_SVH
`ifndef SYNTHESIS
`define SLC_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define SLC_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define SLC_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define SLC_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

>>> hw/rtl/slc_pkg.sv
// Types, constants and the set update function of the split L1 cache.
package slc_pkg;

    localparam int SET_COUNT   = 16384;
    localparam int DATA_WAYS   = 8;
    localparam int INSTR_WAYS  = 4;
    localparam int OFFSET_BITS = 6;

    localparam int SET_W   = $clog2(SET_COUNT);
    localparam int MAX_WAYS = 8;
    localparam int WAY_W   = 3;
    localparam int AGE_W   = 3;
    localparam int DAGE_W  = $clog2(DATA_WAYS);
    localparam int IAGE_W  = $clog2(INSTR_WAYS);
    localparam int TAG_W   = 12;
    localparam int TAG_LSB = 20;
    localparam int ADDR_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 24;

    localparam logic [FUNC_W-1:0] FN_READ  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FETCH = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INVAL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_L2REQ = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd5;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_READ  = 2'd1;
    localparam logic [1:0] BUS_INV   = 2'd2;
    localparam logic [1:0] BUS_RWITM = 2'd3;

    typedef enum logic [1:0] {MESI_I, MESI_E, MESI_S, MESI_M} mesi_t;

    typedef struct packed {
        mesi_t              st;
        logic [TAG_W-1:0]   tag;
        logic [AGE_W-1:0]   age;
    } line_t;
    typedef line_t [MAX_WAYS-1:0] line_arr_t;

    typedef struct packed {
        mesi_t              st;
        logic [TAG_W-1:0]   tag;
        logic [DAGE_W-1:0]  age;
    } dline_t;
    typedef dline_t [DATA_WAYS-1:0] drow_t;

    typedef struct packed {
        mesi_t              st;
        logic [TAG_W-1:0]   tag;
        logic [IAGE_W-1:0]  age;
    } iline_t;
    typedef iline_t [INSTR_WAYS-1:0] irow_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         bus_op;
        logic               snoop_hit;
        logic               writeback;
        logic [TAG_W-1:0]   victim_tag;
        logic               return_data;
        logic [1:0]         new_state;
        logic [WAY_W-1:0]   way;
    } res_t;

    typedef struct packed {
        line_arr_t lines;
        res_t      res;
    } acc_t;

    typedef enum logic [2:0] {CS_INIT, CS_IDLE, CS_UPDATE, CS_CLEAR, CS_CLR_DONE} ctl_state_t;

    typedef struct packed {
        logic               rd_en;
        logic               upd_en;
        logic               clr_en;
        logic [SET_W-1:0]   clr_idx;
        logic               out_load;
        logic               out_zero;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic out_free;
    } ctl_sts_t;

    function automatic line_arr_t d2arr(drow_t d);
        line_arr_t a;
        a = '0;
        for (int j = 0; j < DATA_WAYS; j++)
        begin
            a[j].st  = d[j].st;
            a[j].tag = d[j].tag;
            a[j].age = AGE_W'(d[j].age);
        end
        return a;
    endfunction

    function automatic drow_t arr2d(line_arr_t a);
        drow_t d;
        for (int j = 0; j < DATA_WAYS; j++)
        begin
            d[j].st  = a[j].st;
            d[j].tag = a[j].tag;
            d[j].age = a[j].age[DAGE_W-1:0];
        end
        return d;
    endfunction

    function automatic line_arr_t i2arr(irow_t r);
        line_arr_t a;
        a = '0;
        for (int j = 0; j < INSTR_WAYS; j++)
        begin
            a[j].st  = r[j].st;
            a[j].tag = r[j].tag;
            a[j].age = AGE_W'(r[j].age);
        end
        return a;
    endfunction

    function automatic irow_t arr2i(line_arr_t a);
        irow_t r;
        for (int j = 0; j < INSTR_WAYS; j++)
        begin
            r[j].st  = a[j].st;
            r[j].tag = a[j].tag;
            r[j].age = a[j].age[IAGE_W-1:0];
        end
        return r;
    endfunction

    // One lookup and LRU update of a set; ways above the count are ignored.
    function automatic acc_t cache_access(line_arr_t ln, int ways, logic [TAG_W-1:0] tag,
                                          logic wr, logic snoop);
        acc_t               r;
        logic               found;
        logic               free;
        logic               gfound;
        logic [WAY_W-1:0]   hw;
        logic [WAY_W-1:0]   w;
        logic [AGE_W:0]     lim;
        logic [AGE_W:0]     g;
        logic [MAX_WAYS-1:0] used;
        r.lines = ln;
        r.res   = '0;
        found   = 1'b0;
        free    = 1'b0;
        gfound  = 1'b0;
        hw      = '0;
        w       = '0;
        used    = '0;
        g       = (AGE_W+1)'(ways);
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            if (!found && j < ways && ln[j].st != MESI_I && ln[j].tag == tag)
            begin
                found = 1'b1;
                hw    = WAY_W'(j);
            end
        end
        if (found)
        begin
            lim = {1'b0, ln[hw].age};
        end
        else
        begin
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if (!free && j < ways && ln[j].st == MESI_I)
                begin
                    free = 1'b1;
                    w    = WAY_W'(j);
                end
            end
            for (int a = 0; a < MAX_WAYS; a++)
            begin
                for (int j = 0; j < MAX_WAYS; j++)
                begin
                    if (j < ways && ln[j].st != MESI_I && ln[j].age == AGE_W'(a))
                        used[a] = 1'b1;
                end
            end
            for (int a = 0; a < MAX_WAYS; a++)
            begin
                if (!gfound && a < ways && !used[a])
                begin
                    gfound = 1'b1;
                    g      = (AGE_W+1)'(a);
                end
            end
            if (free)
            begin
                lim = g;
            end
            else
            begin
                for (int j = 1; j < MAX_WAYS; j++)
                begin
                    if (j < ways && ln[j].age > ln[w].age)
                        w = WAY_W'(j);
                end
                if (ln[w].st == MESI_M)
                begin
                    r.res.writeback  = 1'b1;
                    r.res.victim_tag = ln[w].tag;
                end
                lim = {1'b0, ln[w].age};
            end
        end
        // Age every valid line younger than the limit.
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            if (j < ways && ln[j].st != MESI_I && {1'b0, ln[j].age} < lim)
                r.lines[j].age = ln[j].age + 1'b1;
        end
        if (found)
        begin
            r.lines[hw].age = '0;
            r.res.hit = 1'b1;
            if (wr)
            begin
                if (ln[hw].st == MESI_S)
                begin
                    r.res.bus_op    = BUS_INV;
                    r.res.snoop_hit = snoop;
                end
                r.lines[hw].st = MESI_M;
            end
            r.res.new_state = r.lines[hw].st;
            r.res.way       = hw;
        end
        else
        begin
            r.lines[w].age = '0;
            r.lines[w].tag = tag;
            r.lines[w].st  = wr ? MESI_M : (snoop ? MESI_S : MESI_E);
            r.res.bus_op    = wr ? BUS_RWITM : BUS_READ;
            r.res.snoop_hit = snoop;
            r.res.new_state = r.lines[w].st;
            r.res.way       = w;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/split_l1_cache_mesi_lru.sv
// Top level of the split L1 cache tag and MESI state controller.
// Result: the word is loaded in the update state that follows acceptance (set read at
// acceptance, update and result load once the output register is free).
// A new request is accepted only after the read-then-update sequence of the previous one.
// Clear request: every set is cleared, one set per cycle, then a zero result word.
// Reset: asynchronous, active low; afterwards a sweep invalidates every line and
// s_tready stays low until it ends.
module split_l1_cache_mesi_lru (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata fields from bit 0: func[2:0], address[34:3], zero fill[39:35]
    input  logic [slc_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata fields from bit 0: hit, bus_op[2:1], snoop_hit, writeback,
    // victim_tag[16:5], return_data, new_state[19:18], way[22:20], zero fill
    output logic [slc_pkg::OUT_W-1:0]   m_tdata
);
    import slc_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // Sequence each request: read its set, then write the set back and load the result; run clear sweeps.
    slc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the set memories, the lookup and LRU logic and the output word.
    slc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> hw/rtl/slc_dp.sv
// Datapath: set memories, lookup and update logic, output word register.
module slc_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [slc_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [slc_pkg::OUT_W-1:0]   m_tdata,
    input  slc_pkg::ctl_cmd_t           cmd,
    output slc_pkg::ctl_sts_t           sts
);
    import slc_pkg::*;

    drow_t               dmem [SET_COUNT];
    irow_t               imem [SET_COUNT];
    drow_t               drow_reg;
    irow_t               irow_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;

    logic [FUNC_W-1:0]   in_func;
    logic [ADDR_W-1:0]   in_addr;
    logic [SET_W-1:0]    in_set;
    logic [SET_W-1:0]    cur_set;
    logic [TAG_W-1:0]    cur_tag;
    logic                snoop;
    logic                fetch;
    line_arr_t           dl;
    line_arr_t           sel_lines;
    line_arr_t           dl_new;
    line_arr_t           il_new;
    acc_t                acc;
    res_t                res;
    logic                dwe;
    logic                iwe;
    logic                lfound;
    logic [WAY_W-1:0]    lway;

    assign in_func = s_tdata[FUNC_W-1:0];
    assign in_addr = s_tdata[FUNC_W +: ADDR_W];
    assign in_set  = in_addr[OFFSET_BITS +: SET_W];
    assign cur_set = addr_reg[OFFSET_BITS +: SET_W];
    assign cur_tag = addr_reg[TAG_LSB +: TAG_W];
    assign snoop   = ~addr_reg[1];
    assign fetch   = (func_reg == FN_FETCH);

    assign dl        = d2arr(drow_reg);
    assign sel_lines = fetch ? i2arr(irow_reg) : dl;
    assign acc       = cache_access(sel_lines, fetch ? INSTR_WAYS : DATA_WAYS, cur_tag,
                                    func_reg == FN_WRITE, snoop);

    always_comb
    begin
        lfound = 1'b0;
        lway   = '0;
        for (int j = 0; j < DATA_WAYS; j++)
        begin
            if (!lfound && dl[j].st != MESI_I && dl[j].tag == cur_tag)
            begin
                lfound = 1'b1;
                lway   = WAY_W'(j);
            end
        end
    end

    always_comb
    begin
        res    = '0;
        dl_new = dl;
        il_new = acc.lines;
        dwe    = 1'b0;
        iwe    = 1'b0;
        case (func_reg)
            FN_READ, FN_WRITE:
            begin
                dl_new = acc.lines;
                res    = acc.res;
                dwe    = 1'b1;
            end
            FN_FETCH:
            begin
                res = acc.res;
                iwe = 1'b1;
            end
            FN_INVAL, FN_L2REQ:
            begin
                if (lfound)
                begin
                    res.hit         = 1'b1;
                    res.return_data = (func_reg == FN_L2REQ) && (dl[lway].st == MESI_M);
                    res.new_state   = MESI_I;
                    res.way         = lway;
                    dl_new[lway].st = MESI_I;
                    dwe             = 1'b1;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Set memories: one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            dmem[cmd.clr_idx] <= '0;
            imem[cmd.clr_idx] <= '0;
        end
        else if (cmd.upd_en)
        begin
            if (dwe)
                dmem[cur_set] <= arr2d(dl_new);
            if (iwe)
                imem[cur_set] <= arr2i(il_new);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            drow_reg <= dmem[in_set];
            irow_reg <= imem[in_set];
            func_reg <= in_func;
            addr_reg <= in_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_res_reg <= cmd.out_zero ? '0 : res;
    end

    assign sts.in_clear = (in_func == FN_CLEAR);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.way, out_res_reg.new_state, out_res_reg.return_data,
                       out_res_reg.victim_tag, out_res_reg.writeback, out_res_reg.snoop_hit,
                       out_res_reg.bus_op, out_res_reg.hit};

endmodule

>>> hw/rtl/slc_ctrl.sv
// Controller: request sequencing and set clearing sweeps.
`include "split_l1_cache_mesi_lru_defines.svh"
module slc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  slc_pkg::ctl_sts_t   sts,
    output slc_pkg::ctl_cmd_t   cmd
);
    import slc_pkg::*;

    ctl_state_t          state_reg;
    ctl_state_t          state_next;
    logic [SET_W-1:0]    cnt_reg;
    logic [SET_W-1:0]    cnt_next;
    logic                cnt_last;

    assign cnt_last = (cnt_reg == SET_W'(SET_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            CS_INIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                    state_next = CS_IDLE;
            end
            CS_IDLE:
            begin
                cnt_next = '0;
                if (s_tvalid)
                    state_next = sts.in_clear ? CS_CLEAR : CS_UPDATE;
            end
            CS_UPDATE:
            begin
                if (sts.out_free)
                    state_next = CS_IDLE;
            end
            CS_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                    state_next = CS_CLR_DONE;
            end
            CS_CLR_DONE:
            begin
                if (sts.out_free)
                    state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.clr_idx = cnt_reg;
        s_tready    = 1'b0;
        case (state_reg)
            CS_INIT, CS_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            CS_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.rd_en  = s_tvalid;
            end
            CS_UPDATE:
            begin
                cmd.upd_en   = sts.out_free;
                cmd.out_load = sts.out_free;
            end
            CS_CLR_DONE:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_zero = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    `SLC_ASSERT_IMP(a_load_free, clk, rst_n, cmd.upd_en || cmd.out_load, sts.out_free, "result loaded over a waiting word")
    `SLC_ASSERT_IMP(a_clr_excl, clk, rst_n, cmd.clr_en, !cmd.upd_en && !cmd.rd_en && !s_tready, "clear sweep overlaps a request")
    `SLC_ASSERT_NXT(a_rd_next, clk, rst_n, cmd.rd_en, state_reg == CS_UPDATE || state_reg == CS_CLEAR, "accepted request not processed")

endmodule
